FILE: hw/rtl/mwss_pkg.sv
// mwss_pkg: shared item types, command/event codes and constants of the
// mutating window step sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mwss_pkg;

    // Command item fields
    typedef struct packed {
        logic [2:0]  cmd;
        logic        clock_level;
        logic        reset_level;
        logic [4:0]  slot_index;
        logic [15:0] slot_value;
        logic [1:0]  group_index;
    } t_cmd_item;

    // Result item fields
    typedef struct packed {
        logic        event_kind;
        logic [5:0]  step_position;
        logic [15:0] cv_value;
        logic [15:0] cv_inverted;
        logic        gate_active;
    } t_result_item;

    // Command codes
    localparam logic [2:0] CMD_TICK        = 3'd0;
    localparam logic [2:0] CMD_WRITE_SLOT  = 3'd1;
    localparam logic [2:0] CMD_RAND_GROUP  = 3'd2;
    localparam logic [2:0] CMD_CLEAR_GROUP = 3'd3;
    localparam logic [2:0] CMD_RAND_ALL    = 3'd4;

    // Event codes
    localparam logic EVT_STEP    = 1'b0;
    localparam logic EVT_RELEASE = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_START_STEP     = 3'd0;
    localparam logic [2:0] REG_END_STEP       = 3'd1;
    localparam logic [2:0] REG_STEP_INCREMENT = 3'd2;
    localparam logic [2:0] REG_CLOCK_DIVISION = 3'd3;
    localparam logic [2:0] REG_CV_RANGE       = 3'd4;
    localparam logic [2:0] REG_MUTATE_CHANCE  = 3'd5;
    localparam logic [2:0] REG_MODE_FLAGS     = 3'd6;
    localparam logic [2:0] REG_GATE_MODE      = 3'd7;

    // mode_flags bits
    localparam int MODE_WRAP = 0;
    localparam int MODE_TEMP = 1;

    // gate_mode codes
    localparam logic [1:0] GATE_OFF = 2'd0;

    // 10 V in Q4.12
    localparam logic [15:0] FULL_GATE = 16'd40960;

    // Galois LFSR
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Gate thresholds, Q4.12: 0.5 V, 0.75 V, 0.9 V (truncated)
    function automatic logic [11:0] gate_threshold(input logic [1:0] mode);
        logic [11:0] thr;
        case (mode)
            2'd1:    thr = 12'd2048;
            2'd2:    thr = 12'd3072;
            2'd3:    thr = 12'd3686;
            default: thr = 12'd0;
        endcase
        return thr;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mutating_window_step_sequencer_unit.sv
// mutating_window_step_sequencer_unit: top level, APB registers, sequencer.
// Depends on mwss_pkg, mwss_lfsr, mwss_store, mwss_scale.
// Usage: an item is taken when start is high and busy low. Results come out
// as a one-cycle o_strobe with o_result and cannot be stalled; grab them when
// they show. Tick items that make no step (no rising edge, or a divided-away
// edge), gate releases and slot writes keep busy low; a release appears the
// cycle after its tick. A stepping tick runs ADV, RD, LOAD, optional TVAL,
// two passes through the shared scaler (MULA, MULB, WAIT) and FIN, plus,
// with permanent mutation active, a chance draw per slot and a value draw
// per mutated slot first. Group randomize/clear sweep the group's 8 slots,
// randomize-all every slot. Sweeps and mutation are paced by the single
// random source (one draw per cycle) and the store's one write port. Config
// writes are only legal while idle. pready is tied high.
`timescale 1ns / 1ps
`default_nettype none

module mutating_window_step_sequencer_unit
    import mwss_pkg::*;
#(
    parameter int SLOT_COUNT = 32,
    parameter int VALUE_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // command channel
    input  wire logic         start,
    output logic              busy,
    input  wire t_cmd_item    i_item,
    // result channel
    output logic              o_strobe,
    output t_result_item      o_result,
    // APB config
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int IW = (AW > 5) ? AW : 5;          // slot counter, covers group slots
    localparam int PW = $clog2(SLOT_COUNT + 1);
    localparam int PX = (PW > 6) ? PW : 6;          // position register
    localparam int SW = PX + 3;                     // signed window arithmetic
    localparam logic [IW:0] SC_IW = (IW+1)'(SLOT_COUNT);
    localparam logic [VALUE_BITS:0] ONE_V = {1'b1, {VALUE_BITS{1'b0}}};

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_FILL  = 12'b0000_0000_0010,  // group / all store sweep
        ST_PMCHK = 12'b0000_0000_0100,  // permanent mutation, chance draw
        ST_PMVAL = 12'b0000_0000_1000,  // permanent mutation, value draw
        ST_ADV   = 12'b0000_0001_0000,  // move position
        ST_RD    = 12'b0000_0010_0000,  // store read
        ST_LOAD  = 12'b0000_0100_0000,  // latch value, temp chance draw
        ST_TVAL  = 12'b0000_1000_0000,  // temp value draw
        ST_MULA  = 12'b0001_0000_0000,  // scale value
        ST_MULB  = 12'b0010_0000_0000,  // scale complement
        ST_WAIT  = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } t_state;

    // ---------------- configuration registers ----------------
    logic [5:0]  r_start, r_end, r_div;
    logic [4:0]  r_inc;
    logic [15:0] r_range, r_chance;
    logic [1:0]  r_mode, r_gmode;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= 6'd17;
            r_end    <= 6'd32;
            r_inc    <= 5'd1;
            r_div    <= 6'd1;
            r_range  <= 16'd4096;
            r_chance <= 16'd819;
            r_mode   <= 2'd0;
            r_gmode  <= 2'd0;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_START_STEP:     r_start  <= pwdata[5:0];
                REG_END_STEP:       r_end    <= pwdata[5:0];
                REG_STEP_INCREMENT: r_inc    <= pwdata[4:0];
                REG_CLOCK_DIVISION: r_div    <= pwdata[5:0];
                REG_CV_RANGE:       r_range  <= pwdata[15:0];
                REG_MUTATE_CHANCE:  r_chance <= pwdata[15:0];
                REG_MODE_FLAGS:     r_mode   <= pwdata[1:0];
                REG_GATE_MODE:      r_gmode  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_START_STEP:     prdata = 32'(r_start);
            REG_END_STEP:       prdata = 32'(r_end);
            REG_STEP_INCREMENT: prdata = 32'(r_inc);
            REG_CLOCK_DIVISION: prdata = 32'(r_div);
            REG_CV_RANGE:       prdata = 32'(r_range);
            REG_MUTATE_CHANCE:  prdata = 32'(r_chance);
            REG_MODE_FLAGS:     prdata = 32'(r_mode);
            REG_GATE_MODE:      prdata = 32'(r_gmode);
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer state ----------------
    t_state                r_state, n_state;
    logic [IW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_left, n_left;
    logic                  r_fill_rnd, n_fill_rnd;
    logic [PX-1:0]         r_pos, n_pos;
    logic [5:0]            r_divc, n_divc;
    logic                  r_restart, n_restart;
    logic                  r_prev_clk, n_prev_clk;
    logic                  r_prev_rst, n_prev_rst;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [15:0]           r_cv, n_cv;
    t_result_item          r_out, n_out;
    logic                  r_strobe, n_strobe;

    // Q0.16 draw to store format
    function automatic logic [VALUE_BITS-1:0] to_value(input logic [15:0] x);
        logic [VALUE_BITS+15:0] w;
        w = {x, {VALUE_BITS{1'b0}}};
        return w[VALUE_BITS+15:16];
    endfunction

    // ---------------- shared units ----------------
    logic [15:0]           lfsr_next;
    logic                  lfsr_adv;
    logic                  draw_hit;
    logic [VALUE_BITS-1:0] draw_val;

    mwss_lfsr u_lfsr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (lfsr_adv),
        .o_next  (lfsr_next)
    );

    assign draw_hit = lfsr_next < r_chance;
    assign draw_val = to_value(lfsr_next);

    logic                  st_we;
    logic [AW-1:0]         st_waddr, st_raddr;
    logic [VALUE_BITS-1:0] st_wdata, st_rdata;
    logic [PX-1:0]         pos_m1;

    assign pos_m1   = r_pos - 1'b1;
    assign st_raddr = pos_m1[AW-1:0];

    mwss_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    logic [VALUE_BITS:0] sc_frac;
    logic [15:0]         sc_res;

    mwss_scale #(
        .VALUE_BITS (VALUE_BITS)
    ) u_scale (
        .i_clk       (i_clk),
        .i_frac      (sc_frac),
        .i_range     (r_range),
        .i_gate_mode (r_gmode),
        .o_result    (sc_res)
    );

    // ---------------- clock divider ----------------
    logic [5:0] div_cl, div_inc, div_next;

    assign div_cl   = (r_div == 6'd0) ? 6'd1 : ((r_div > 6'd32) ? 6'd32 : r_div);
    assign div_inc  = r_divc + 6'd1;
    assign div_next = (div_inc >= div_cl) ? 6'd0 : div_inc;

    // ---------------- window move ----------------
    // Forward when end >= start, reverse otherwise. Wrap folds by window
    // length; without wrap, running off the window restarts at start.
    logic [PX-1:0] adv_pos;

    always_comb begin
        logic signed [SW-1:0] a_sc, a_st, a_en, a_s, a_e, a_inc, a_len, a_p;
        a_sc = SW'(SLOT_COUNT);
        a_st = SW'(r_start);
        a_en = SW'(r_end);
        if (a_st < SW'(1))      a_s = SW'(1);
        else if (a_st > a_sc)   a_s = a_sc;
        else                    a_s = a_st;
        if (a_en < SW'(1))      a_e = SW'(1);
        else if (a_en > a_sc)   a_e = a_sc;
        else                    a_e = a_en;
        if (r_inc == 5'd0)      a_inc = SW'(1);
        else if (r_inc > 5'd16) a_inc = SW'(16);
        else                    a_inc = SW'(r_inc);
        a_len = a_e - a_s + SW'(1);
        a_p   = SW'(r_pos);
        if (r_restart) begin
            a_p = a_s;
        end else if (a_len >= SW'(1)) begin
            a_p = a_p + a_inc;
            if (a_p > a_e) a_p = r_mode[MODE_WRAP] ? a_p - a_len : a_s;
            if (a_p < a_s || a_p > a_e) a_p = a_s;
        end else begin
            a_p = a_p - a_inc;
            if (a_p > a_s) a_p = a_s;
            if (a_p < a_e) a_p = r_mode[MODE_WRAP] ? a_s + a_p - a_e + SW'(1) : a_s;
            if (a_p < a_e || a_p > a_s) a_p = a_s;
        end
        adv_pos = a_p[PX-1:0];
    end

    // ---------------- control ----------------
    logic          accept;
    logic [IW-1:0] slot_iw;
    logic          fill_ok, slot_ok, perm_last;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign slot_iw   = IW'(i_item.slot_index);
    assign slot_ok   = {1'b0, slot_iw} < SC_IW;
    assign fill_ok   = {1'b0, r_idx} < SC_IW;
    assign perm_last = {1'b0, r_idx} == (SC_IW - 1'b1);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_left     = r_left;
        n_fill_rnd = r_fill_rnd;
        n_pos      = r_pos;
        n_divc     = r_divc;
        n_restart  = r_restart;
        n_prev_clk = r_prev_clk;
        n_prev_rst = r_prev_rst;
        n_val      = r_val;
        n_cv       = r_cv;
        n_out      = r_out;
        n_strobe   = 1'b0;
        lfsr_adv   = 1'b0;
        st_we      = 1'b0;
        st_waddr   = r_idx[AW-1:0];
        st_wdata   = draw_val;
        sc_frac    = {1'b0, r_val};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_item.cmd)
                        CMD_WRITE_SLOT: begin
                            st_we    = slot_ok;
                            st_waddr = slot_iw[AW-1:0];
                            st_wdata = to_value(i_item.slot_value);
                        end
                        CMD_RAND_GROUP, CMD_CLEAR_GROUP: begin
                            n_idx      = IW'({i_item.group_index, 3'b000});
                            n_left     = AW'(7);
                            n_fill_rnd = (i_item.cmd == CMD_RAND_GROUP);
                            n_state    = ST_FILL;
                        end
                        CMD_RAND_ALL: begin
                            n_idx      = '0;
                            n_left     = AW'(SLOT_COUNT - 1);
                            n_fill_rnd = 1'b1;
                            n_state    = ST_FILL;
                        end
                        CMD_TICK: begin
                            n_prev_rst = i_item.reset_level;
                            n_prev_clk = i_item.clock_level;
                            if (i_item.reset_level && !r_prev_rst) begin
                                n_restart = 1'b1;
                            end
                            if (i_item.clock_level && !r_prev_clk) begin
                                n_divc = div_next;
                                if (div_next == 6'd0) begin
                                    n_idx = '0;
                                    if (r_chance != 16'd0 && !r_mode[MODE_TEMP]) begin
                                        n_state = ST_PMCHK;
                                    end else begin
                                        n_state = ST_ADV;
                                    end
                                end
                            end else if (!i_item.clock_level && r_prev_clk &&
                                         r_gmode != GATE_OFF) begin
                                // falling edge drops the gates
                                n_strobe              = 1'b1;
                                n_out.event_kind      = EVT_RELEASE;
                                n_out.step_position   = r_pos[5:0];
                                n_out.cv_value        = 16'd0;
                                n_out.cv_inverted     = 16'd0;
                                n_out.gate_active     = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                // random draw is taken even for slots past the store
                st_we    = fill_ok;
                st_wdata = r_fill_rnd ? draw_val : '0;
                lfsr_adv = r_fill_rnd;
                n_idx    = r_idx + 1'b1;
                n_left   = r_left - 1'b1;
                if (r_left == '0) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PMCHK: begin
                lfsr_adv = 1'b1;
                if (draw_hit) begin
                    n_state = ST_PMVAL;
                end else if (perm_last) begin
                    n_state = ST_ADV;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_PMVAL: begin
                lfsr_adv = 1'b1;
                st_we    = 1'b1;
                if (perm_last) begin
                    n_state = ST_ADV;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_PMCHK;
                end
            end
            ST_ADV: begin
                n_pos     = adv_pos;
                n_restart = 1'b0;
                n_state   = ST_RD;
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_val   = st_rdata;
                n_state = ST_MULA;
                if (r_mode[MODE_TEMP]) begin
                    // one chance draw per step, even at zero chance
                    lfsr_adv = 1'b1;
                    if (draw_hit) begin
                        n_state = ST_TVAL;
                    end
                end
            end
            ST_TVAL: begin
                lfsr_adv = 1'b1;
                n_val    = draw_val;
                n_state  = ST_MULA;
            end
            ST_MULA: begin
                sc_frac = {1'b0, r_val};
                n_state = ST_MULB;
            end
            ST_MULB: begin
                sc_frac = ONE_V - {1'b0, r_val};
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                n_cv    = sc_res;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_strobe            = 1'b1;
                n_out.event_kind    = EVT_STEP;
                n_out.step_position = r_pos[5:0];
                n_out.cv_value      = r_cv;
                n_out.cv_inverted   = sc_res;
                n_out.gate_active   = (r_gmode != GATE_OFF);
                n_state             = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pos      <= '0;
            r_divc     <= 6'd63;
            r_restart  <= 1'b1;
            r_prev_clk <= 1'b0;
            r_prev_rst <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_divc     <= n_divc;
            r_restart  <= n_restart;
            r_prev_clk <= n_prev_clk;
            r_prev_rst <= n_prev_rst;
            r_strobe   <= n_strobe;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_left     <= n_left;
        r_fill_rnd <= n_fill_rnd;
        r_val      <= n_val;
        r_cv       <= n_cv;
        r_out      <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // ---------------- checks ----------------
    // step results only leave from FIN
    a_step_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.event_kind == EVT_STEP) |-> $past(r_state == ST_FIN))
        else $error("step result without a finished step");

    // gate outputs are only 0 V or 10 V
    a_gate_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.gate_active) |->
            ((r_out.cv_value == 16'd0 || r_out.cv_value == FULL_GATE) &&
             (r_out.cv_inverted == 16'd0 || r_out.cv_inverted == FULL_GATE)))
        else $error("gate output not at a rail");

    // position lands inside the store after a move
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_pos >= PX'(1) && r_pos <= PX'(SLOT_COUNT)))
        else $error("position outside store after move");

    // busy only rises from an accepted item
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a start");

endmodule

`default_nettype wire

FILE: hw/rtl/mwss_lfsr.sv
// mwss_lfsr: 16-bit Galois random source, one draw per advance.
// Depends on mwss_pkg (seed, taps).
`timescale 1ns / 1ps
`default_nettype none

module mwss_lfsr
    import mwss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    output logic [15:0]      o_next
);

    logic [15:0] r_lfsr;

    // value returned by the draw taken this cycle
    assign o_next = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LFSR_SEED;
        end else if (i_adv) begin
            r_lfsr <= o_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mwss_store.sv
// mwss_store: step store memory, one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
`timescale 1ns / 1ps
`default_nettype none

module mwss_store #(
    parameter int SLOT_COUNT = 32,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_we,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_waddr,
    input  wire logic [VALUE_BITS-1:0]         i_wdata,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] i_raddr,
    output logic [VALUE_BITS-1:0]              o_rdata
);

    logic [VALUE_BITS-1:0] r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld;
    logic [VALUE_BITS-1:0] r_rdata;
    logic                  r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/mwss_scale.sv
// mwss_scale: shared two-stage scaler, fraction times cv_range then
// truncate to Q4.12 or compare against the gate threshold. Uses mwss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwss_scale
    import mwss_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic [VALUE_BITS:0]   i_frac,
    input  wire logic [15:0]           i_range,
    input  wire logic [1:0]            i_gate_mode,
    output logic [15:0]                o_result
);

    localparam int PB = VALUE_BITS + 17;

    logic [PB-1:0] r_prod;
    logic [15:0]   r_res;
    logic [PB-1:0] thr_w;

    // threshold aligned with the product's fraction point
    assign thr_w = PB'({gate_threshold(i_gate_mode), {VALUE_BITS{1'b0}}});

    always_ff @(posedge i_clk) begin
        r_prod <= PB'(i_frac) * PB'(i_range);
        if (i_gate_mode != GATE_OFF) begin
            r_res <= (r_prod > thr_w) ? FULL_GATE : 16'd0;
        end else begin
            r_res <= r_prod[VALUE_BITS+15:VALUE_BITS];
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire
